// ===== hw/rtl/npsu_pkg.sv =====
// ----------------------------------------------------------------------------
// npsu_pkg : shared types and constants of the nearest point search unit
// Operation and status codes, distance limits and the scan tag carried
// through the distance pipeline.
// ----------------------------------------------------------------------------
package npsu_pkg;

    // operation codes on the input tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // status codes on the output tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    localparam int DIST_W = 33;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    // smallest per-axis magnitude whose square exceeds DIST_MAX
    localparam int SAT_LIM = 92682;
    localparam int MAG_W = 17;
    localparam int IDX_OUT_W = 10;
    localparam int FIELD_W = 16;

    // control of one scan slot moving through the distance pipeline
    typedef struct packed {
        logic valid;   // slot holds a stored point below the fill count
        logic last;    // final slot of the scan
    } t_tag;

endpackage

// ===== hw/rtl/npsu_cell.sv =====
// ----------------------------------------------------------------------------
// npsu_cell : one storage cell of the point ring
// Holds one point. Takes its neighbor's point on a shift, or a new point
// on a write.
// ----------------------------------------------------------------------------
module npsu_cell #(
    parameter int CW = 16
) (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_write,
    input  logic [CW-1:0] i_next_x,
    input  logic [CW-1:0] i_next_y,
    input  logic [CW-1:0] i_wr_x,
    input  logic [CW-1:0] i_wr_y,
    output logic [CW-1:0] o_x,
    output logic [CW-1:0] o_y
);

    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;

    // point register, no reset: read only after written
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end else if (i_write) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== hw/rtl/npsu_dist.sv =====
// ----------------------------------------------------------------------------
// npsu_dist : two-stage squared distance pipeline
// Stage one forms axis magnitudes and saturation flags, stage two squares them with
// saturation. Point, index and tag ride along.
// ----------------------------------------------------------------------------
module npsu_dist
    import npsu_pkg::*;
#(
    parameter int CW = 16,
    parameter int IW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  logic [IW-1:0]     i_idx,
    input  logic [CW-1:0]     i_px,
    input  logic [CW-1:0]     i_py,
    input  logic [CW-1:0]     i_qx,
    input  logic [CW-1:0]     i_qy,
    output t_tag              o_tag,
    output logic [IW-1:0]     o_idx,
    output logic [CW-1:0]     o_px,
    output logic [CW-1:0]     o_py,
    output logic [DIST_W-1:0] o_sqx,
    output logic [DIST_W-1:0] o_sqy
);

    localparam int EXT_W = CW + MAG_W + 1;

    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW:0]        mx;
    logic [CW:0]        my;
    logic [EXT_W-1:0]   ex;
    logic [EXT_W-1:0]   ey;

    t_tag             r_tag1, r_tag2;
    logic [IW-1:0]    r_idx1, r_idx2;
    logic [CW-1:0]    r_px1, r_py1, r_px2, r_py2;
    logic [MAG_W-1:0] r_mx, r_my;
    logic             r_satx, r_saty;
    logic [DIST_W-1:0] r_sqx, r_sqy;
    logic [2*MAG_W-1:0] prodx, prody;

    // signed differences and magnitudes
    always_comb begin
        dx = $signed({i_px[CW-1], i_px}) - $signed({i_qx[CW-1], i_qx});
        dy = $signed({i_py[CW-1], i_py}) - $signed({i_qy[CW-1], i_qy});
        mx = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
        my = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
        ex = {{(MAG_W){1'b0}}, mx};
        ey = {{(MAG_W){1'b0}}, my};
    end

    assign prodx = r_mx * r_mx;
    assign prody = r_my * r_my;

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_px1  <= i_px;
        r_py1  <= i_py;
        r_mx   <= ex[MAG_W-1:0];
        r_my   <= ey[MAG_W-1:0];
        r_satx <= ex >= EXT_W'(SAT_LIM);
        r_saty <= ey >= EXT_W'(SAT_LIM);
        r_idx2 <= r_idx1;
        r_px2  <= r_px1;
        r_py2  <= r_py1;
        r_sqx  <= r_satx ? DIST_MAX : prodx[DIST_W-1:0];
        r_sqy  <= r_saty ? DIST_MAX : prody[DIST_W-1:0];
    end

    assign o_tag = r_tag2;
    assign o_idx = r_idx2;
    assign o_px  = r_px2;
    assign o_py  = r_py2;
    assign o_sqx = r_sqx;
    assign o_sqy = r_sqy;

endmodule

// ===== hw/rtl/nearest_point_search_2d_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search_2d_unit : linear scan nearest point search
// Points sit in a ring of cells. A query rotates the ring once past a
// distance pipeline at the head and keeps the closest point seen.
//
// channel   dir  tdata                                   tuser
// s_axis    in   point_x, point_y                        operation
// m_axis    out  nearest_x, nearest_y, index, distance   status
//
// Insert, clear and unused codes load their result straight on acceptance.
// A query passes through one full ring rotation, the two-stage distance
// pipeline, the compare register and the result load.
// Reset empties the table at once; stored points have no reset.
// A stalled result holds off the next beat; the scan itself never stalls.
// ----------------------------------------------------------------------------
module nearest_point_search_2d_unit
    import npsu_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // point_x[15:0], point_y[31:16]
    input  logic [1:0]  i_s_axis_tuser,   // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // nearest_x, nearest_y, nearest_index,
                                          // distance_sq, zero pad
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int CW    = COORD_WIDTH;
    localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [IW-1:0]    LAST_K = IW'(MAX_POINTS - 1);
    localparam logic [CNT_W-1:0] FULL_N = CNT_W'(MAX_POINTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [IW-1:0]     r_k;
    logic              r_feed;
    logic [CW-1:0]     r_qx, r_qy;
    logic              r_first;
    logic [DIST_W-1:0] r_best_d;
    logic [IW-1:0]     r_best_idx;
    logic [CW-1:0]     r_best_x, r_best_y;
    logic              r_ov;
    logic [1:0]        r_ostat;
    logic [FIELD_W-1:0] r_ox, r_oy;
    logic [IDX_OUT_W-1:0] r_oidx;
    logic [DIST_W-1:0] r_od;

    logic [CW-1:0]     cx [MAX_POINTS];
    logic [CW-1:0]     cy [MAX_POINTS];
    logic [CW+FIELD_W-1:0] in_x_ext, in_y_ext;
    logic [CW-1:0]     in_x, in_y;
    logic              accept;
    t_op               op;
    logic              shift;
    logic              wr_en;

    t_tag              feed_tag, d_tag;
    logic [IW-1:0]     d_idx;
    logic [CW-1:0]     d_px, d_py;
    logic [DIST_W-1:0] d_sqx, d_sqy;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] d_dist;
    logic              take;
    logic [DIST_W-1:0] n_best_d;
    logic [IW-1:0]     n_best_idx;
    logic [CW-1:0]     n_best_x, n_best_y;
    logic [FIELD_W+CW-1:0] bx_ext, by_ext;
    logic [IDX_OUT_W+IW-1:0] bidx_ext, widx_ext;

    // input decode
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ov || i_m_axis_tready);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign op       = t_op'(i_s_axis_tuser);
    assign in_x_ext = {{CW{1'b0}}, i_s_axis_tdata[15:0]};
    assign in_y_ext = {{CW{1'b0}}, i_s_axis_tdata[31:16]};
    assign in_x     = in_x_ext[CW-1:0];
    assign in_y     = in_y_ext[CW-1:0];
    // ring rotates exactly MAX_POINTS times per query
    assign shift    = r_feed;
    assign wr_en    = accept && (op == OP_INSERT) && (r_count < FULL_N);

    // ring of point cells, head at cell 0
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        npsu_cell #(.CW(CW)) u_cell (
            .i_clk    (i_clk),
            .i_shift  (shift),
            .i_write  (wr_en && (r_count == CNT_W'(g))),
            .i_next_x (cx[(g + 1) % MAX_POINTS]),
            .i_next_y (cy[(g + 1) % MAX_POINTS]),
            .i_wr_x   (in_x),
            .i_wr_y   (in_y),
            .o_x      (cx[g]),
            .o_y      (cy[g])
        );
    end

    // slot tag for the point now at the head
    always_comb begin
        feed_tag.valid = shift && (CNT_W'(r_k) < r_count);
        feed_tag.last  = shift && (r_k == LAST_K);
    end

    npsu_dist #(.CW(CW), .IW(IW)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (feed_tag),
        .i_idx   (r_k),
        .i_px    (cx[0]),
        .i_py    (cy[0]),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_tag   (d_tag),
        .o_idx   (d_idx),
        .o_px    (d_px),
        .o_py    (d_py),
        .o_sqx   (d_sqx),
        .o_sqy   (d_sqy)
    );

    // sum with saturation and running minimum, later entry wins a tie
    always_comb begin
        sum    = {1'b0, d_sqx} + {1'b0, d_sqy};
        d_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        take   = d_tag.valid && (r_first || (d_dist <= r_best_d));
        n_best_d   = take ? d_dist : r_best_d;
        n_best_idx = take ? d_idx  : r_best_idx;
        n_best_x   = take ? d_px   : r_best_x;
        n_best_y   = take ? d_py   : r_best_y;
        bx_ext   = {{FIELD_W{1'b0}}, r_best_x};
        by_ext   = {{FIELD_W{1'b0}}, r_best_y};
        bidx_ext = {{IDX_OUT_W{1'b0}}, r_best_idx};
        widx_ext = {{IDX_OUT_W{1'b0}}, r_count[IW-1:0]};
    end

    // best-so-far registers
    always_ff @(posedge i_clk) begin
        r_best_d   <= n_best_d;
        r_best_idx <= n_best_idx;
        r_best_x   <= n_best_x;
        r_best_y   <= n_best_y;
        if (accept) begin
            r_qx <= in_x;
            r_qy <= in_y;
        end
    end

    // control, scan counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_feed  <= 1'b0;
            r_first <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (take) begin
                r_first <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ostat <= ST_OK;
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_oidx  <= '0;
                        r_od    <= '0;
                        case (op)
                            OP_INSERT: begin
                                r_ov <= 1'b1;
                                if (r_count < FULL_N) begin
                                    r_oidx  <= widx_ext[IDX_OUT_W-1:0];
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ostat <= ST_FULL;
                                end
                            end
                            OP_QUERY: begin
                                if (r_count == '0) begin
                                    r_ov    <= 1'b1;
                                    r_ostat <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN;
                                    r_k     <= '0;
                                    r_feed  <= 1'b1;
                                    r_first <= 1'b1;
                                end
                            end
                            OP_CLEAR: begin
                                r_ov    <= 1'b1;
                                r_count <= '0;
                            end
                            default: begin
                                r_ov <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // feed stops after the last slot, then the pipeline drains
                    if (r_k != LAST_K) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_feed <= 1'b0;
                    end
                    if (d_tag.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_ostat <= ST_OK;
                        r_ox    <= bx_ext[FIELD_W-1:0];
                        r_oy    <= by_ext[FIELD_W-1:0];
                        r_oidx  <= bidx_ext[IDX_OUT_W-1:0];
                        r_od    <= r_best_d;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tdata  = {5'b0, r_od, r_oidx, r_oy, r_ox};

`ifndef SYNTHESIS
    // fill count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_N)
        else $error("fill count beyond table size");

    // an insert with room grows the table by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the table");

    // the distance pipeline is empty once the scan is over
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !d_tag.valid)
        else $error("distance slot in flight after scan end");

    // no input beat is accepted while a scan runs
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !accept)
        else $error("beat accepted during scan");
`endif

endmodule

// ===== tb/sv/tb_nearest_point_search_2d_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_point_search_2d_unit : self-checking bench of the nearest point unit
// Drives insert, query, clear and unused beats with random gaps on both
// streams, predicts each result from a private copy of the point table and
// compares every output beat field by field in order.
// ----------------------------------------------------------------------------
module tb_nearest_point_search_2d_unit;
    import npsu_pkg::*;

    localparam int NPTS     = 1024;
    localparam int WDOG_MAX = 40000;

    typedef struct {
        t_status         st;
        logic [15:0]     nx;
        logic [15:0]     ny;
        logic [9:0]      idx;
        logic [DIST_W-1:0] dsq;
    } t_answer;

    // nearest point predictor with its own table, plus the pending answers
    class nearest_scoreboard;
        logic [15:0] tab_x[NPTS];
        logic [15:0] tab_y[NPTS];
        int          fill;
        t_answer     pending[$];
        int          errors;

        function void note_beat(t_op op, logic [15:0] px, logic [15:0] py);
            t_answer a;
            longint dx, dy, d, best_d;
            int best;
            a = '{ST_OK, 16'd0, 16'd0, 10'd0, '0};
            case (op)
                OP_INSERT: begin
                    if (fill >= NPTS) a.st = ST_FULL;
                    else begin
                        tab_x[fill] = px;
                        tab_y[fill] = py;
                        a.idx = fill[9:0];
                        fill++;
                    end
                end
                OP_QUERY: begin
                    if (fill == 0) a.st = ST_EMPTY;
                    else begin
                        best = 0;
                        best_d = 0;
                        for (int i = 0; i < fill; i++) begin
                            dx = longint'($signed(tab_x[i])) - longint'($signed(px));
                            dy = longint'($signed(tab_y[i])) - longint'($signed(py));
                            d = dx * dx + dy * dy;
                            // later entry wins a tie
                            if (i == 0 || d <= best_d) begin
                                best_d = d;
                                best = i;
                            end
                        end
                        a.nx = tab_x[best];
                        a.ny = tab_y[best];
                        a.idx = best[9:0];
                        a.dsq = best_d[DIST_W-1:0];
                    end
                end
                OP_CLEAR: fill = 0;
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        function void check_beat(logic [79:0] data, logic [1:0] user);
            t_answer e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat tdata=%h tuser=%h", $realtime, data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (user !== e.st) begin
                $display("%0t: status exp %0d got %0d", $realtime, e.st, user);
                errors++;
            end
            if (data[15:0] !== e.nx) begin
                $display("%0t: nearest_x exp %h got %h", $realtime, e.nx, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.ny) begin
                $display("%0t: nearest_y exp %h got %h", $realtime, e.ny, data[31:16]);
                errors++;
            end
            if (data[41:32] !== e.idx) begin
                $display("%0t: index exp %0d got %0d", $realtime, e.idx, data[41:32]);
                errors++;
            end
            if (data[74:42] !== e.dsq) begin
                $display("%0t: distance exp %0d got %0d", $realtime, e.dsq, data[74:42]);
                errors++;
            end
            if (data[79:75] !== 5'd0) begin
                $display("%0t: pad exp 0 got %h", $realtime, data[79:75]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    nearest_scoreboard sb;
    int  wdog;
    bit  stim_done;

    nearest_point_search_2d_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // output side: random stall, check each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_beat(o_m_axis_tdata, o_m_axis_tuser);
        i_m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("[nearest_point_search_2d_unit] ERROR");
            $finish;
        end
    end

    // valid stays up after a beat; it drops only for a gap or a drain
    task automatic send_beat(t_op op, logic [15:0] px, logic [15:0] py);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_beat(op, px, py);
    endtask

    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_op op;
        int  r, n;
        sb = new();
        sb.fill = 0;
        sb.errors = 0;
        wdog = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty query, extremes, tie, unused code, clear
        send_beat(OP_QUERY, 16'h0000, 16'h0000);
        send_beat(OP_NONE, 16'hffff, 16'hffff);
        send_beat(OP_INSERT, 16'h8000, 16'h8000);
        send_beat(OP_QUERY, 16'h7fff, 16'h7fff);
        send_beat(OP_INSERT, 16'h7fff, 16'h7fff);
        send_beat(OP_QUERY, 16'h8000, 16'h8000);
        send_beat(OP_QUERY, 16'h0000, 16'h0000);
        send_beat(OP_INSERT, 16'h0100, 16'h0000);
        send_beat(OP_INSERT, 16'hff00, 16'h0000);
        send_beat(OP_QUERY, 16'h0000, 16'h0000);   // tie, higher index wins
        send_beat(OP_INSERT, 16'h0100, 16'h0000);
        send_beat(OP_QUERY, 16'h0100, 16'h0000);   // exact duplicate tie
        send_beat(OP_NONE, 16'h1234, 16'h5678);
        send_beat(OP_QUERY, 16'h0080, 16'hff80);
        send_beat(OP_CLEAR, 16'h5555, 16'haaaa);
        send_beat(OP_QUERY, 16'h0000, 16'h0000);
        send_beat(OP_INSERT, 16'h5555, 16'haaaa);
        send_beat(OP_QUERY, 16'haaaa, 16'h5555);

        // sender holds off until all answers are back
        wait_drain();

        // back-to-back insert run on top of the one stored point
        for (int i = 0; i < 200; i++) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tuser  <= OP_INSERT;
            i_s_axis_tdata  <= {rnd_coord(), rnd_coord()};
            do @(posedge i_clk); while (!o_s_axis_tready);
            sb.note_beat(OP_INSERT, i_s_axis_tdata[15:0], i_s_axis_tdata[31:16]);
        end
        send_beat(OP_INSERT, 16'h0001, 16'h0001);
        send_beat(OP_QUERY, rnd_coord(), rnd_coord());
        send_beat(OP_QUERY, 16'h8000, 16'h7fff);
        send_beat(OP_CLEAR, 16'h0000, 16'h0000);

        // random: mostly short insert runs followed by queries
        n = 0;
        while (n < 360) begin
            r = $urandom_range(0, 99);
            if (r < 55) op = OP_INSERT;
            else if (r < 88) op = OP_QUERY;
            else if (r < 96) op = (sb.fill > 24) ? OP_CLEAR : OP_INSERT;
            else op = OP_NONE;
            send_beat(op, rnd_coord(), rnd_coord());
            n++;
            if (n == 180) wait_drain();
        end

        wait_drain();
        repeat (NPTS + 20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[nearest_point_search_2d_unit] OK");
        else
            $display("[nearest_point_search_2d_unit] ERROR");
        $finish;
    end

endmodule
